FILE: rtl/noise_gap_segment_selector_unit_assert.svh
// Assertion macros for the noise gap segment selector.
// NGS_ASSERT_NOW: consequent checked in the same cycle as the antecedent.
// NGS_ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef NOISE_GAP_SEGMENT_SELECTOR_UNIT_ASSERT_SVH
`define NOISE_GAP_SEGMENT_SELECTOR_UNIT_ASSERT_SVH

`ifndef SYNTH
`define NGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ngs assertion failed");
`define NGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ngs assertion failed");
`else
`define NGS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define NGS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/ngs_pkg.sv
package ngs_pkg;

    localparam int FIELD_W        = 20;
    localparam int WIN_W          = 16;
    localparam int BUDGET_W       = 20;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 20;
    localparam int INDEX_BITS_DEF = 20;

    localparam logic [CFG_IDX_W-1:0] REG_PRE_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUDGET     = 2'd2;

    typedef struct packed {
        logic awaiting_first;
        logic budget_done;
    } t_flags;

    typedef struct packed {
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               fin;
    } t_seg;

endpackage

FILE: rtl/ngs_if.sv
interface ngs_item_if #(
    parameter int INDEX_BITS = ngs_pkg::INDEX_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] peak_idx;
    logic                  last_peak;

    modport source (output valid, output peak_idx, output last_peak, input ready);
    modport sink   (input valid, input peak_idx, input last_peak, output ready);
endinterface

interface ngs_seg_if;
    logic                         valid;
    logic                         ready;
    logic [ngs_pkg::FIELD_W-1:0]  segment_start;
    logic [ngs_pkg::FIELD_W-1:0]  segment_length;
    logic                         final_segment;

    modport source (output valid, output segment_start, output segment_length,
                    output final_segment, input ready);
    modport sink   (input valid, input segment_start, input segment_length,
                    input final_segment, output ready);
endinterface

interface ngs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ngs_pkg::CFG_IDX_W-1:0]   index;
    logic [ngs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/noise_gap_segment_selector_unit.sv
// Channel  Direction  Handshake          Payload
// i_item   in         valid/ready        peak_idx, last_peak
// o_seg    out        valid/ready        segment_start, segment_length, final_segment
// i_cfg    in         valid/ready        index, data (0 pre window, 1 decay, 2 budget)
//
// One item per cycle sustained while the result is not stalled. An accepted item
// waits in the input register and moves to the result register when it advances,
// where any result is offered; the per-peak state updates when the item moves on.
// A stalled result holds the result register while one more item waits in the
// input register. Synchronous active-low reset clears the valid bits, the per-buffer
// state and the configuration registers.
`include "noise_gap_segment_selector_unit_assert.svh"

module noise_gap_segment_selector_unit #(
    parameter int INDEX_BITS = ngs_pkg::INDEX_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ngs_item_if.sink  i_item,
    ngs_seg_if.source o_seg,
    ngs_cfg_if.sink   i_cfg
);
    import ngs_pkg::*;

    logic [WIN_W:0]        window;
    logic [BUDGET_W-1:0]   budget;

    logic                  r_in_valid;
    logic [INDEX_BITS-1:0] r_in_peak;
    logic                  r_in_last;

    t_flags                r_flags;
    logic [INDEX_BITS-1:0] r_prev;
    logic [INDEX_BITS-1:0] r_count;

    logic                  r_out_valid;
    t_seg                  r_out;

    logic                  advance;
    logic                  emit;
    t_seg                  seg;
    t_flags                n_flags;
    logic [INDEX_BITS-1:0] n_prev;
    logic [INDEX_BITS-1:0] n_count;

    ngs_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_window (window),
        .o_budget (budget)
    );

    ngs_gap_calc #(.INDEX_BITS(INDEX_BITS)) u_calc (
        .i_flags      (r_flags),
        .i_prev_start (r_prev),
        .i_collected  (r_count),
        .i_window     (window),
        .i_budget     (budget),
        .i_peak       (r_in_peak),
        .i_last       (r_in_last),
        .o_emit       (emit),
        .o_seg        (seg),
        .o_next_flags (n_flags),
        .o_next_prev  (n_prev),
        .o_next_count (n_count)
    );

    assign advance      = r_in_valid && (!r_out_valid || o_seg.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_peak <= i_item.peak_idx;
            r_in_last <= i_item.last_peak;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '{awaiting_first: 1'b1, budget_done: 1'b0};
            r_prev  <= '0;
            r_count <= '0;
        end else if (advance) begin
            r_flags <= n_flags;
            r_prev  <= n_prev;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (o_seg.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= seg;
        end
    end

    assign o_seg.valid          = r_out_valid;
    assign o_seg.segment_start  = r_out.start;
    assign o_seg.segment_length = r_out.length;
    assign o_seg.final_segment  = r_out.fin;

    `NGS_ASSERT_NOW(a_fresh_state, i_clk, i_rst_n, r_flags.awaiting_first,
                    (r_prev == '0 && r_count == '0))
    `NGS_ASSERT_NOW(a_done_after_first, i_clk, i_rst_n, r_flags.budget_done,
                    !r_flags.awaiting_first)
    `NGS_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, advance && r_in_last,
                     r_flags.awaiting_first && !r_flags.budget_done)
    `NGS_ASSERT_NOW(a_quiet_when_done, i_clk, i_rst_n, advance && r_flags.budget_done, !emit)

endmodule

FILE: rtl/ngs_cfg_regs.sv
module ngs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ngs_cfg_if.sink                       i_cfg,
    output logic [ngs_pkg::WIN_W:0]       o_window,
    output logic [ngs_pkg::BUDGET_W-1:0]  o_budget
);
    import ngs_pkg::*;

    logic [WIN_W-1:0]    r_pre_window;
    logic [WIN_W-1:0]    r_decay;
    logic [BUDGET_W-1:0] r_budget;
    logic                cfg_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_window <= '0;
            r_decay      <= '0;
            r_budget     <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (i_cfg.index)
                    REG_PRE_WINDOW: r_pre_window <= i_cfg.data[WIN_W-1:0];
                    REG_DECAY:      r_decay      <= i_cfg.data[WIN_W-1:0];
                    REG_BUDGET:     r_budget     <= i_cfg.data[BUDGET_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // pulse extent: pre-peak window plus decay
    assign o_window = {1'b0, r_pre_window} + {1'b0, r_decay};
    assign o_budget = r_budget;

endmodule

FILE: rtl/ngs_gap_calc.sv
module ngs_gap_calc #(
    parameter int INDEX_BITS = ngs_pkg::INDEX_BITS_DEF
) (
    input  ngs_pkg::t_flags               i_flags,
    input  logic [INDEX_BITS-1:0]         i_prev_start,
    input  logic [INDEX_BITS-1:0]         i_collected,
    input  logic [ngs_pkg::WIN_W:0]       i_window,
    input  logic [ngs_pkg::BUDGET_W-1:0]  i_budget,
    input  logic [INDEX_BITS-1:0]         i_peak,
    input  logic                          i_last,
    output logic                          o_emit,
    output ngs_pkg::t_seg                 o_seg,
    output ngs_pkg::t_flags               o_next_flags,
    output logic [INDEX_BITS-1:0]         o_next_prev,
    output logic [INDEX_BITS-1:0]         o_next_count
);
    import ngs_pkg::*;

    localparam int GW = ((INDEX_BITS > WIN_W + 1) ? INDEX_BITS : WIN_W + 1) + 1;
    localparam int CW = (INDEX_BITS + 1 > BUDGET_W) ? INDEX_BITS + 1 : BUDGET_W;

    logic [GW-1:0]         gap_begin;
    logic                  too_close;
    logic                  take;
    logic [GW-1:0]         from;
    logic [INDEX_BITS-1:0] len;
    logic [CW-1:0]         newlen;
    logic [CW-1:0]         remain;
    logic [CW-1:0]         clamped;
    logic                  over;

    assign gap_begin = GW'(i_prev_start) + GW'(i_window);
    assign too_close = GW'(i_peak) < gap_begin;
    assign newlen    = CW'(len) + CW'(i_collected);
    assign over      = newlen > CW'(i_budget);
    assign remain    = (CW'(i_budget) > CW'(i_collected)) ?
                       CW'(i_budget) - CW'(i_collected) : '0;
    assign clamped   = (CW'(len) < remain) ? CW'(len) : remain;

    always_comb begin
        take = 1'b0;
        from = '0;
        len  = '0;
        if (!i_flags.budget_done) begin
            if (i_flags.awaiting_first) begin
                // a peak at sample zero began in the previous buffer
                take = (i_peak != '0);
                len  = i_peak;
            end else begin
                take = !too_close;
                from = gap_begin;
                len  = INDEX_BITS'(GW'(i_peak) - gap_begin);
            end
        end
    end

    always_comb begin
        o_emit       = 1'b0;
        o_seg        = '0;
        o_next_flags = i_flags;
        o_next_prev  = i_prev_start;
        o_next_count = i_collected;
        if (i_flags.budget_done) begin
            o_emit = 1'b0;
        end else if (!take) begin
            // skipped peak: only a last one reports a closing empty segment
            o_emit    = i_last;
            o_seg.fin = 1'b1;
        end else begin
            o_emit                      = 1'b1;
            o_seg.start                 = FIELD_W'(from);
            o_next_flags.awaiting_first = 1'b0;
            o_next_prev                 = i_peak;
            if (over || i_last) begin
                o_seg.length             = FIELD_W'(clamped);
                o_seg.fin                = 1'b1;
                o_next_flags.budget_done = 1'b1;
            end else begin
                o_seg.length = FIELD_W'(len);
                o_next_count = INDEX_BITS'(newlen);
            end
        end
        if (i_last) begin
            o_next_flags.awaiting_first = 1'b1;
            o_next_flags.budget_done    = 1'b0;
            o_next_prev                 = '0;
            o_next_count                = '0;
        end
    end

endmodule
